>>> sv/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants for the power channel sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pcs_pkg;

  // Stream and register port widths
  localparam int unsigned TDATA_W  = 16;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;

  // Fixed lengths of the power-on sequence waits, in ticks
  localparam logic [15:0] RELAY_SETTLE_TICKS = 16'd100;
  localparam logic [15:0] PULSE_TICKS        = 16'd100;
  localparam logic [15:0] GAP_TICKS          = 16'd50;
  localparam logic [15:0] ACTIVATE_TICKS     = 16'd200;

  // Phase codes
  localparam logic [2:0] PH_RUN      = 3'd0;
  localparam logic [2:0] PH_DEBOUNCE = 3'd1;
  localparam logic [2:0] PH_RELAY    = 3'd2;
  localparam logic [2:0] PH_PULSE    = 3'd3;
  localparam logic [2:0] PH_GAP      = 3'd4;
  localparam logic [2:0] PH_ACTIVATE = 3'd5;
  localparam logic [2:0] PH_FAULT    = 3'd6;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_TEMP_LIMIT    = 3'd0;
  localparam logic [2:0] REG_IGN_TIMEOUT   = 3'd1;
  localparam logic [2:0] REG_POWER_ENABLE  = 3'd2;
  localparam logic [2:0] REG_DEBOUNCE      = 3'd3;
  localparam logic [2:0] REG_FAULT_OFF     = 3'd4;
  localparam logic [2:0] REG_MAX_RETRIES   = 3'd5;

  // Register reset values
  localparam logic [11:0] TEMP_LIMIT_RST   = 12'd960;
  localparam logic [31:0] IGN_TIMEOUT_RST  = 32'd60000;
  localparam logic [9:0]  DEBOUNCE_RST     = 10'd50;
  localparam logic [15:0] FAULT_OFF_RST    = 16'd30000;
  localparam logic [3:0]  MAX_RETRIES_RST  = 4'd3;

  // One result item, last field in the lowest bit
  typedef struct packed {
    logic [2:0] phase_now;
    logic       ch1_held_off;
    logic [3:0] retries_used;
    logic       powered;
    logic       ch4_on;
    logic       ch3_on;
    logic       ch2_on;
    logic       ch1_on;
    logic       relay_on;
  } pcs_result_t;

endpackage

`default_nettype wire

>>> sv/power_channel_sequencer_top.sv
// ----------------------------------------------------------------------------
// power_channel_sequencer_top
// Tick-driven relay and channel power sequencer with ignition debounce,
// over-temperature and ignition-off shutdown, and channel 1 fault retry.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Content
//  in_       slave      tvalid / tready           one tick: ignition, fault, temp
//  out_      master     tvalid / tready           outputs and phase after the tick
//  cfg_      APB slave  psel / penable / pready   six control registers
//
// One tick transaction per clock sustained while out_tready is high. A tick is
// captured in the input register, its state update is computed from there
// and lands in the result register together with the new sequencer state.
// The input stage keeps accepting while a result waits, and stalls only when
// both the input and result registers are full and out_tready is low.
// rst_n is synchronous; it restores the register defaults and the idle state.
`default_nettype none

module power_channel_sequencer_top (
  input  wire                          clk,
  input  wire                          rst_n,
  // tdata: [0] ign_level, [1] fault_level, [13:2] temp_sample, [15:14] zero
  input  wire [pcs_pkg::TDATA_W-1:0]   in_tdata,
  // tuser: [0] temp_valid
  input  wire                          in_tuser,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // tdata: [0] relay_on, [1] ch1_on, [2] ch2_on, [3] ch3_on, [4] ch4_on,
  //        [5] powered, [9:6] retries_used, [10] ch1_held_off,
  //        [13:11] phase_now, [15:14] zero
  output logic [pcs_pkg::TDATA_W-1:0]  out_tdata,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire  [pcs_pkg::PADDR_W-1:0]  cfg_paddr,
  input  wire  [pcs_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [pcs_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  import pcs_pkg::*;

  // Configuration registers
  logic signed [11:0] temp_limit_r;
  logic [31:0]        ign_timeout_r;
  logic               power_enable_r;
  logic [9:0]         debounce_r;
  logic [15:0]        fault_off_r;
  logic [3:0]         max_retries_r;

  // Sequencer state
  logic [2:0]         phase_r,   phase_nxt;
  logic [15:0]        wait_r,    wait_nxt;
  logic               ign_r,     ign_nxt;
  logic [31:0]        since_r,   since_nxt;
  logic signed [11:0] temp_r,    temp_nxt;
  logic [3:0]         chan_r,    chan_nxt;
  logic               relay_r,   relay_nxt;
  logic               done_r,    done_nxt;
  logic [3:0]         retry_r,   retry_nxt;
  logic               held_nxt;

  // Pipeline registers
  logic [TDATA_W-1:0] in_data_r;
  logic               in_user_r;
  logic               in_vld_r;
  logic [TDATA_W-1:0] out_data_r;
  logic               out_vld_r;

  // Working signals
  logic               advance;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  logic               cur_ign;
  logic               cur_fault;
  logic [15:0]        wlen;
  logic               do_ign;
  logic               do_pwr;
  logic               hot;
  logic               timed;
  pcs_result_t        res;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_limit_r   <= TEMP_LIMIT_RST;
      ign_timeout_r  <= IGN_TIMEOUT_RST;
      power_enable_r <= 1'b1;
      debounce_r     <= DEBOUNCE_RST;
      fault_off_r    <= FAULT_OFF_RST;
      max_retries_r  <= MAX_RETRIES_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TEMP_LIMIT:   temp_limit_r   <= cfg_pwdata[11:0];
        REG_IGN_TIMEOUT:  ign_timeout_r  <= cfg_pwdata;
        REG_POWER_ENABLE: power_enable_r <= cfg_pwdata[0];
        REG_DEBOUNCE:     debounce_r     <= cfg_pwdata[9:0];
        REG_FAULT_OFF:    fault_off_r    <= cfg_pwdata[15:0];
        REG_MAX_RETRIES:  max_retries_r  <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_idx)
      REG_TEMP_LIMIT:   cfg_prdata = {20'd0, temp_limit_r};
      REG_IGN_TIMEOUT:  cfg_prdata = ign_timeout_r;
      REG_POWER_ENABLE: cfg_prdata = {31'd0, power_enable_r};
      REG_DEBOUNCE:     cfg_prdata = {22'd0, debounce_r};
      REG_FAULT_OFF:    cfg_prdata = {16'd0, fault_off_r};
      REG_MAX_RETRIES:  cfg_prdata = {28'd0, max_retries_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: input register feeds the update, result register holds output
  // --------------------------------------------------------------------------
  assign advance   = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_user_r <= in_tuser;
    end
  end

  assign cur_ign   = in_data_r[0];
  assign cur_fault = in_data_r[1];

  // Length of the wait in the current phase
  always_comb begin
    unique case (phase_r)
      PH_DEBOUNCE: wlen = {6'd0, debounce_r};
      PH_RELAY:    wlen = RELAY_SETTLE_TICKS;
      PH_PULSE:    wlen = PULSE_TICKS;
      PH_GAP:      wlen = GAP_TICKS;
      PH_ACTIVATE: wlen = ACTIVATE_TICKS;
      PH_FAULT:    wlen = fault_off_r;
      default:     wlen = 16'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Tick update
  // --------------------------------------------------------------------------
  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    ign_nxt   = ign_r;
    since_nxt = since_r;
    temp_nxt  = temp_r;
    chan_nxt  = chan_r;
    relay_nxt = relay_r;
    done_nxt  = done_r;
    retry_nxt = retry_r;
    held_nxt  = 1'b0;
    do_ign    = 1'b0;
    do_pwr    = 1'b0;
    hot       = 1'b0;
    timed     = 1'b0;

    if (since_nxt != '1) since_nxt = since_nxt + 32'd1;

    if (phase_r != PH_RUN) begin
      if (phase_r > PH_FAULT) begin
        phase_nxt = PH_RUN;
        wait_nxt  = 16'd0;
      end else begin
        if (wait_nxt != '1) wait_nxt = wait_nxt + 16'd1;
        // Wait expired: finish the phase; after a fault or debounce wait, carry on in the same tick
        if (wait_nxt >= wlen) begin
          phase_nxt = PH_RUN;
          wait_nxt  = 16'd0;
          unique case (phase_r)
            PH_FAULT: begin
              chan_nxt[0] = 1'b1;
              if (retry_nxt != 4'hF) retry_nxt = retry_nxt + 4'd1;
              if (retry_nxt >= max_retries_r) begin
                chan_nxt[0] = 1'b0;
                held_nxt    = 1'b1;
              end
              do_ign = 1'b1;
            end
            PH_DEBOUNCE: begin
              if (cur_ign != ign_nxt) begin
                ign_nxt   = cur_ign;
                since_nxt = 32'd0;
              end
              do_pwr = 1'b1;
            end
            PH_RELAY: begin
              chan_nxt[0] = 1'b1;
              phase_nxt   = PH_PULSE;
            end
            PH_PULSE: begin
              chan_nxt[0] = 1'b0;
              phase_nxt   = PH_GAP;
            end
            PH_GAP: begin
              chan_nxt[0] = 1'b1;
              phase_nxt   = PH_ACTIVATE;
            end
            PH_ACTIVATE: begin
              chan_nxt[3:1] = 3'b111;
              done_nxt      = 1'b1;
            end
            default: ;
          endcase
        end
      end
    end else begin
      // Run phase: latch temperature, then channel 1 fault handling
      if (in_user_r) temp_nxt = in_data_r[13:2];
      if (chan_nxt[0] && cur_fault) begin
        if (retry_nxt < max_retries_r) begin
          chan_nxt[0] = 1'b0;
          phase_nxt   = PH_FAULT;
          wait_nxt    = 16'd0;
          // Zero off time: the retry completes in this tick
          if (fault_off_r == 16'd0) begin
            phase_nxt   = PH_RUN;
            chan_nxt[0] = 1'b1;
            if (retry_nxt != 4'hF) retry_nxt = retry_nxt + 4'd1;
            if (retry_nxt >= max_retries_r) begin
              chan_nxt[0] = 1'b0;
              held_nxt    = 1'b1;
            end
            do_ign = 1'b1;
          end
        end else begin
          chan_nxt[0] = 1'b0;
          held_nxt    = 1'b1;
          do_ign      = 1'b1;
        end
      end else begin
        do_ign = 1'b1;
      end
    end

    // Ignition check: a changed level starts the debounce wait, or is taken at once when debounce is zero
    if (do_ign) begin
      if (cur_ign != ign_nxt) begin
        phase_nxt = PH_DEBOUNCE;
        wait_nxt  = 16'd0;
        if (debounce_r == 10'd0) begin
          phase_nxt = PH_RUN;
          ign_nxt   = cur_ign;
          since_nxt = 32'd0;
          do_pwr    = 1'b1;
        end
      end else begin
        do_pwr = 1'b1;
      end
    end

    // Power logic: shutdown conditions, else start the power-on sequence
    if (do_pwr) begin
      hot   = temp_nxt >= temp_limit_r;
      timed = !ign_nxt && (since_nxt >= ign_timeout_r);
      if (power_enable_r) begin
        if (hot || timed) begin
          if (done_nxt) begin
            chan_nxt  = 4'd0;
            relay_nxt = 1'b0;
            done_nxt  = 1'b0;
          end
        end else if (ign_nxt && !done_nxt) begin
          relay_nxt = 1'b1;
          phase_nxt = PH_RELAY;
          wait_nxt  = 16'd0;
        end
      end else if (done_nxt) begin
        chan_nxt  = 4'd0;
        relay_nxt = 1'b0;
        done_nxt  = 1'b0;
      end
    end
  end

  // Result item from the updated state
  always_comb begin
    res.relay_on     = relay_nxt;
    res.ch1_on       = chan_nxt[0];
    res.ch2_on       = chan_nxt[1];
    res.ch3_on       = chan_nxt[2];
    res.ch4_on       = chan_nxt[3];
    res.powered      = done_nxt;
    res.retries_used = retry_nxt;
    res.ch1_held_off = held_nxt;
    res.phase_now    = phase_nxt;
  end

  // --------------------------------------------------------------------------
  // State and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_RUN;
      wait_r    <= 16'd0;
      ign_r     <= 1'b0;
      since_r   <= 32'd0;
      temp_r    <= 12'sd0;
      chan_r    <= 4'd0;
      relay_r   <= 1'b0;
      done_r    <= 1'b0;
      retry_r   <= 4'd0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
      if (in_vld_r) begin
        phase_r <= phase_nxt;
        wait_r  <= wait_nxt;
        ign_r   <= ign_nxt;
        since_r <= since_nxt;
        temp_r  <= temp_nxt;
        chan_r  <= chan_nxt;
        relay_r <= relay_nxt;
        done_r  <= done_nxt;
        retry_r <= retry_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r) begin
      out_data_r <= {{(TDATA_W - $bits(pcs_result_t)){1'b0}}, res};
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_vld_r;

endmodule

`default_nettype wire
